// File: sv/hvfm_pkg.sv
// ============================================================================
// hvfm_pkg
// Shared types, codes and constants of the height-map voxel face mesher.
// ============================================================================
package hvfm_pkg;

  // fixed field widths
  localparam int Y_W       = 10;
  localparam int QNUM_W    = 20;
  localparam int FACE_W    = 3;
  localparam int NCLS_W    = 2;
  localparam int TEX_W     = 2;
  localparam int CMD_W     = 2;

  // default geometry
  localparam int CHUNK_SIDE_DEF = 16;
  localparam int COLUMN_HEIGHT  = 256;

  // water level after reset
  localparam logic [Y_W-1:0] WATER_RESET = Y_W'(64);

  // input item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_EMIT   = 2'd2
  } cmd_e;

  // scan phases
  typedef enum logic [1:0] {
    PH_COL_START = 2'd0,
    PH_IN_COLUMN = 2'd1,
    PH_WATER     = 2'd2,
    PH_DONE      = 2'd3
  } phase_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP_LD,
    ST_STEP,
    ST_COL_LD,
    ST_FACE_EVAL,
    ST_WATER_EVAL
  } state_e;

  // face codes, plus the end-of-block marker
  localparam logic [FACE_W-1:0] FACE_PX  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ  = 3'd5;
  localparam logic [FACE_W-1:0] FACE_END = 3'd6;

  // normal classes
  localparam logic [NCLS_W-1:0] NCLS_SIDE_X = 2'd0;
  localparam logic [NCLS_W-1:0] NCLS_TOP    = 2'd1;
  localparam logic [NCLS_W-1:0] NCLS_BOTTOM = 2'd2;
  localparam logic [NCLS_W-1:0] NCLS_SIDE_Z = 2'd3;

  // textures
  localparam logic [TEX_W-1:0] TEX_GRASS = 2'd0;
  localparam logic [TEX_W-1:0] TEX_DIRT  = 2'd1;
  localparam logic [TEX_W-1:0] TEX_WATER = 2'd2;

  // normal class of a face
  function automatic logic [NCLS_W-1:0] normal_of(input logic [FACE_W-1:0] face);
    logic [NCLS_W-1:0] ncls;
    unique case (face)
      FACE_PX, FACE_NX: ncls = NCLS_SIDE_X;
      FACE_PY:          ncls = NCLS_TOP;
      FACE_NY:          ncls = NCLS_BOTTOM;
      default:          ncls = NCLS_SIDE_Z;
    endcase
    return ncls;
  endfunction

endpackage

// File: sv/hvfm_ram.sv
// ============================================================================
// hvfm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hvfm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 324,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/heightmap_voxel_face_mesher.sv
// ============================================================================
// heightmap_voxel_face_mesher
// Holds a column-height map with a one-cell halo; an emit command hands out
// one visible quad (terrain faces, then water tops) or, when done, an empty one.
// ============================================================================
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------
//  command   start_i / busy_o          command_i, grid_x_i, grid_z_i,
//                                      column_height_i
//  result    done_o (one-cycle strobe) quad_valid_o, anchor_*_o,
//                                      face_direction_o, normal_class_o,
//                                      texture_id_o, flip_v_o, quad_number_o
//  config    cfg_valid_i / cfg_ready_o cfg_data_i (water level)
//
//  write, rewind and unused commands leave busy_o low.
//  an emit loads the top, then per terrain column a column load and one check
//  per face tried, then one check per column in the water pass; every
//  check waits on one read of the height RAM.
//  reset clears the scan cursors and counter and sets the water level to WATER_RESET; the height map
//  keeps whatever it holds and must be written before it is scanned.
//  results cannot be stalled: done_o is high for exactly one cycle.
//
module heightmap_voxel_face_mesher #(
  parameter int CHUNK_SIDE = hvfm_pkg::CHUNK_SIDE_DEF,
  localparam int HALO   = CHUNK_SIDE + 2,
  localparam int GRID_W = $clog2(HALO + 1),
  localparam int AW     = $clog2(CHUNK_SIDE + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hvfm_pkg::CMD_W-1:0]    command_i,
  input  logic [GRID_W-1:0]             grid_x_i,
  input  logic [GRID_W-1:0]             grid_z_i,
  input  logic [hvfm_pkg::Y_W-1:0]      column_height_i,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hvfm_pkg::Y_W-1:0]      cfg_data_i,
  // result channel
  output logic                          done_o,
  output logic                          quad_valid_o,
  output logic [AW-1:0]                 anchor_x_o,
  output logic [hvfm_pkg::Y_W-1:0]      anchor_y_o,
  output logic [AW-1:0]                 anchor_z_o,
  output logic [hvfm_pkg::FACE_W-1:0]   face_direction_o,
  output logic [hvfm_pkg::NCLS_W-1:0]   normal_class_o,
  output logic [hvfm_pkg::TEX_W-1:0]    texture_id_o,
  output logic                          flip_v_o,
  output logic [hvfm_pkg::QNUM_W-1:0]   quad_number_o
);
  import hvfm_pkg::*;

  localparam int DEPTH  = HALO * HALO;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = Y_W + 1;

  // sequencer and scan state
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [AW-1:0]       x_q, x_d;
  logic [AW-1:0]       z_q, z_d;
  logic [Y_W-1:0]      y_q, y_d;
  logic [FACE_W-1:0]   face_q, face_d;
  logic                had_q, had_d;
  logic [QNUM_W-1:0]   cnt_q, cnt_d;
  logic [Y_W-1:0]      top_q, top_d;
  logic [Y_W-1:0]      water_q;

  // result registers
  logic                done_q, done_d;
  logic                qv_q, qv_d;
  logic [AW-1:0]       ax_q, ax_d;
  logic [Y_W-1:0]      ay_q, ay_d;
  logic [AW-1:0]       az_q, az_d;
  logic [FACE_W-1:0]   dir_q, dir_d;
  logic [NCLS_W-1:0]   ncls_q, ncls_d;
  logic [TEX_W-1:0]    tex_q, tex_d;
  logic                flip_q, flip_d;
  logic [QNUM_W-1:0]   qnum_q, qnum_d;

  // ram and address signals
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [Y_W-1:0]      rd_data;
  logic [GRID_W-1:0]   own_hx, own_hz, nb_hx, nb_hz;
  logic [GRID_W-1:0]   off_x, off_z;

  // shared compare unit
  logic [CMP_W-1:0]    ny;
  logic [CMP_W-1:0]    cmp_a, cmp_b;
  logic                cmp_ge;
  logic                out_of_range, visible, face_emit, water_hit;

  logic                accept;
  logic                x_end;
  logic [AW-1:0]       nc_x, nc_z;
  cmd_e                cmd;

  assign accept      = start_i && !busy_o;
  assign cmd         = cmd_e'(command_i);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign x_end       = (x_q >= AW'(CHUNK_SIDE));

  // next column, x-major then z
  always_comb begin
    nc_x = x_q;
    nc_z = z_q + AW'(1);
    if (nc_z >= AW'(CHUNK_SIDE)) begin
      nc_z = '0;
      nc_x = x_q + AW'(1);
    end
  end

  // halo addresses of the own column and of the face neighbour
  always_comb begin
    off_x = GRID_W'(1);
    off_z = GRID_W'(1);
    case (face_q)
      FACE_PX: off_x = GRID_W'(2);
      FACE_NX: off_x = '0;
      FACE_PZ: off_z = GRID_W'(2);
      FACE_NZ: off_z = '0;
      default: ;
    endcase
  end

  assign own_hx = GRID_W'(x_q) + GRID_W'(1);
  assign own_hz = GRID_W'(z_q) + GRID_W'(1);
  assign nb_hx  = GRID_W'(x_q) + off_x;
  assign nb_hz  = GRID_W'(z_q) + off_z;

  // read address: the neighbour while stepping a column, else the own column
  always_comb begin
    if (state_q == ST_STEP && phase_q == PH_IN_COLUMN) begin
      rd_addr = ADDR_W'(nb_hx) * ADDR_W'(HALO) + ADDR_W'(nb_hz);
    end else begin
      rd_addr = ADDR_W'(own_hx) * ADDR_W'(HALO) + ADDR_W'(own_hz);
    end
  end

  // height map writes, dropped outside the halo map
  assign wr_en   = accept && (cmd == CMD_WRITE) &&
                   (grid_x_i < GRID_W'(HALO)) && (grid_z_i < GRID_W'(HALO));
  assign wr_addr = ADDR_W'(grid_x_i) * ADDR_W'(HALO) + ADDR_W'(grid_z_i);

  hvfm_ram #(
    .WIDTH (Y_W),
    .DEPTH (DEPTH)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (column_height_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // neighbour y of the face under test
  always_comb begin
    case (face_q)
      FACE_PY: ny = {1'b0, y_q} + CMP_W'(1);
      FACE_NY: ny = {1'b0, y_q} - CMP_W'(1);
      default: ny = {1'b0, y_q};
    endcase
  end

  // one comparator: visibility against a height, or height against water
  always_comb begin
    if (state_q == ST_WATER_EVAL) begin
      cmp_a = {1'b0, rd_data};
      cmp_b = {1'b0, water_q};
    end else begin
      cmp_a = ny;
      cmp_b = {1'b0, rd_data};
    end
  end

  assign cmp_ge       = (cmp_a >= cmp_b);
  assign out_of_range = (face_q == FACE_NY && y_q == '0) || (ny >= CMP_W'(COLUMN_HEIGHT));
  assign visible      = out_of_range || cmp_ge;
  assign face_emit    = visible && !(face_q == FACE_NY && y_q == '0);
  assign water_hit    = !cmp_ge;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd == CMD_EMIT) begin
          state_d = ST_TOP_LD;
        end
      end
      ST_TOP_LD: state_d = ST_STEP;
      ST_STEP: begin
        unique case (phase_q)
          PH_COL_START: state_d = x_end ? ST_STEP : ST_COL_LD;
          PH_IN_COLUMN: state_d = (face_q == FACE_END) ? ST_STEP : ST_FACE_EVAL;
          PH_WATER:     state_d = x_end ? ST_STEP : ST_WATER_EVAL;
          default:      state_d = ST_IDLE;
        endcase
      end
      ST_COL_LD:     state_d = ST_STEP;
      ST_FACE_EVAL:  state_d = face_emit ? ST_IDLE : ST_STEP;
      ST_WATER_EVAL: state_d = water_hit ? ST_IDLE : ST_STEP;
      default:       state_d = ST_IDLE;
    endcase
  end

  // scan datapath and result values
  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    z_d     = z_q;
    y_d     = y_q;
    face_d  = face_q;
    had_d   = had_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    done_d  = 1'b0;
    qv_d    = qv_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    az_d    = az_q;
    dir_d   = dir_q;
    ncls_d  = ncls_q;
    tex_d   = tex_q;
    flip_d  = flip_q;
    qnum_d  = qnum_q;
    unique case (state_q)
      ST_IDLE: begin
        // rewind keeps the map and the water level
        if (accept && cmd == CMD_REWIND) begin
          phase_d = PH_COL_START;
          x_d     = '0;
          z_d     = '0;
          y_d     = '0;
          face_d  = FACE_PX;
          had_d   = 1'b0;
          cnt_d   = '0;
        end
      end
      ST_TOP_LD: top_d = rd_data;
      ST_STEP: begin
        unique case (phase_q)
          PH_COL_START: begin
            if (x_end) begin
              x_d     = '0;
              z_d     = '0;
              phase_d = PH_WATER;
            end
          end
          PH_IN_COLUMN: begin
            // block finished: go down, or leave the column
            if (face_q == FACE_END) begin
              if (!had_q || y_q == '0) begin
                x_d     = nc_x;
                z_d     = nc_z;
                phase_d = PH_COL_START;
              end else begin
                y_d    = y_q - Y_W'(1);
                face_d = FACE_PX;
                had_d  = 1'b0;
              end
            end
          end
          PH_WATER: begin
            if (x_end) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            // scan finished: empty result with the total count
            done_d = 1'b1;
            qv_d   = 1'b0;
            ax_d   = '0;
            ay_d   = '0;
            az_d   = '0;
            dir_d  = '0;
            ncls_d = '0;
            tex_d  = '0;
            flip_d = 1'b0;
            qnum_d = cnt_q;
          end
        endcase
      end
      ST_COL_LD: begin
        y_d     = rd_data;
        top_d   = rd_data;
        face_d  = FACE_PX;
        had_d   = 1'b0;
        phase_d = PH_IN_COLUMN;
      end
      ST_FACE_EVAL: begin
        face_d = face_q + FACE_W'(1);
        if (visible) begin
          had_d = 1'b1;
        end
        if (face_emit) begin
          done_d = 1'b1;
          qv_d   = 1'b1;
          ax_d   = x_q + AW'(face_q == FACE_PX);
          ay_d   = y_q + Y_W'(face_q == FACE_PY);
          az_d   = z_q + AW'(face_q == FACE_PZ);
          dir_d  = face_q;
          ncls_d = normal_of(face_q);
          tex_d  = (y_q == top_q) ? TEX_GRASS : TEX_DIRT;
          flip_d = (face_q == FACE_NZ);
          qnum_d = cnt_q;
          cnt_d  = cnt_q + QNUM_W'(1);
        end
      end
      ST_WATER_EVAL: begin
        x_d = nc_x;
        z_d = nc_z;
        if (water_hit) begin
          done_d = 1'b1;
          qv_d   = 1'b1;
          ax_d   = x_q;
          ay_d   = water_q;
          az_d   = z_q;
          dir_d  = FACE_PY;
          ncls_d = NCLS_TOP;
          tex_d  = TEX_WATER;
          flip_d = 1'b0;
          qnum_d = cnt_q;
          cnt_d  = cnt_q + QNUM_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_COL_START;
      x_q     <= '0;
      z_q     <= '0;
      y_q     <= '0;
      face_q  <= FACE_PX;
      had_q   <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      x_q     <= x_d;
      z_q     <= z_d;
      y_q     <= y_d;
      face_q  <= face_d;
      had_q   <= had_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // water level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_q <= WATER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      water_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    qv_q   <= qv_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    az_q   <= az_d;
    dir_q  <= dir_d;
    ncls_q <= ncls_d;
    tex_q  <= tex_d;
    flip_q <= flip_d;
    qnum_q <= qnum_d;
  end

  assign done_o           = done_q;
  assign quad_valid_o     = qv_q;
  assign anchor_x_o       = ax_q;
  assign anchor_y_o       = ay_q;
  assign anchor_z_o       = az_q;
  assign face_direction_o = dir_q;
  assign normal_class_o   = ncls_q;
  assign texture_id_o     = tex_q;
  assign flip_v_o         = flip_q;
  assign quad_number_o    = qnum_q;

`ifndef SYNTH
  // a result only appears once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // every quad handed out moves the running count on by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && quad_valid_o) |-> (cnt_q == quad_number_o + QNUM_W'(1)))
    else $error("quad count out of step");

  // face checks happen only inside a column with a face left to try
  a_face_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FACE_EVAL) |-> (phase_q == PH_IN_COLUMN && face_q < FACE_END))
    else $error("face check outside a column");

  // the scan cursor never passes the end of the chunk
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_q <= AW'(CHUNK_SIDE)) && (z_q < AW'(CHUNK_SIDE)) && (face_q <= FACE_END))
    else $error("scan cursor out of range");
`endif

endmodule
